// File: rtl/frf_pkg.sv
// Shared constants, types and twiddle table of the ramp filter row block.
package frf_pkg;

   localparam int ROW_LENGTH  = 1024;
   localparam int LOG_LEN     = $clog2(ROW_LENGTH);
   localparam int HALF_LEN    = ROW_LENGTH / 2;
   localparam int QUARTER_LEN = ROW_LENGTH / 4;
   localparam int STAGE_W     = $clog2(LOG_LEN);
   localparam int SAMPLE_W    = 16;
   localparam int RESULT_W    = 24;
   localparam int WORK_W      = 32;
   localparam int COEF_W      = 18;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef logic [LOG_LEN-1:0] addr_type;
   typedef logic [LOG_LEN-2:0] tw_idx_type;
   typedef logic [15:0] qsin_tab_type [0:QUARTER_LEN];

   typedef enum logic [4:0] {
      PS_COPY = 5'b00001,
      PS_FFT  = 5'b00010,
      PS_REV  = 5'b00100,
      PS_RAMP = 5'b01000,
      PS_OUT  = 5'b10000
   } pass_type;

   typedef struct packed {
      pass_type                 pass;
      logic                     inv;
      logic                     cap;
      logic                     mul;
      logic                     wq;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
   } frf_ctl_type;

   // round(sin(2*pi*m/N) * 2^15) by a Q30 series, capped at 32767
   function automatic logic [15:0] quarter_sine(input int unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned q;
      x    = (64'd2 * PI_Q30 * 64'(m)) >> LOG_LEN;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      // term n is x^(2n+1) / (2n+1)!, signs alternating
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd506; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd600; sum = sum + term;
      q = (sum + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      return q[15:0];
   endfunction

   function automatic qsin_tab_type build_qsin();
      qsin_tab_type t;
      for (int unsigned m = 0; m <= QUARTER_LEN; m++) begin
         t[m] = quarter_sine(m);
      end
      return t;
   endfunction

   localparam qsin_tab_type QSIN_TAB = build_qsin();

endpackage

// File: rtl/frf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/frf_bfly.sv
// Butterfly, ramp and copy datapath of the ramp filter row block.
module frf_bfly (
   input  logic                          clock,
   input  frf_pkg::frf_ctl_type          ctl,
   input  logic [2*frf_pkg::WORK_W-1:0]  wk_a_data,
   input  logic [2*frf_pkg::WORK_W-1:0]  wk_b_data,
   input  logic [frf_pkg::SAMPLE_W-1:0]  ld_data,
   output logic [2*frf_pkg::WORK_W-1:0]  wk_wr_data,
   output logic [frf_pkg::RESULT_W-1:0]  res_wr_data
);
   import frf_pkg::*;

   logic signed [32:0] sr_ff, si_ff, ar_ff, ai_ff;
   logic signed [32:0] sr_in, si_in, ar_in, ai_in;
   logic signed [50:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [50:0] m0_in, m1_in, m2_in, m3_in;
   logic signed [31:0] ra, rai, rb, rbi;
   logic signed [51:0] re52, im52, re_r, im_r;
   logic signed [33:0] hr, hi;
   logic [2*WORK_W-1:0] prod_word, p_word;
   logic fwd;

   function automatic logic [31:0] sat32(input logic signed [51:0] v);
      if (v > 52'sd2147483647)       return 32'h7FFF_FFFF;
      else if (v < -52'sd2147483648) return 32'h8000_0000;
      else                           return v[31:0];
   endfunction

   function automatic logic [RESULT_W-1:0] sat24(input logic signed [32:0] v);
      if (v > 33'sd8388607)       return 24'h7F_FFFF;
      else if (v < -33'sd8388608) return 24'h80_0000;
      else                        return v[RESULT_W-1:0];
   endfunction

   assign ra  = $signed(wk_a_data[63:32]);
   assign rai = $signed(wk_a_data[31:0]);
   assign rb  = $signed(wk_b_data[63:32]);
   assign rbi = $signed(wk_b_data[31:0]);

   // capture: sums and differences, or raw operands
   always_comb begin
      sr_in = sr_ff;
      si_in = si_ff;
      ar_in = ar_ff;
      ai_in = ai_ff;
      if (ctl.cap) begin
         case (ctl.pass)
            PS_COPY: begin
               sr_in = 33'($signed(ld_data));
               si_in = '0;
               ar_in = '0;
               ai_in = '0;
            end
            PS_FFT: begin
               sr_in = 33'(ra) + 33'(rb);
               si_in = 33'(rai) + 33'(rbi);
               ar_in = 33'(ra) - 33'(rb);
               ai_in = 33'(rai) - 33'(rbi);
            end
            PS_REV: begin
               sr_in = 33'(rb);
               si_in = 33'(rbi);
               ar_in = 33'(ra);
               ai_in = 33'(rai);
            end
            default: begin
               sr_in = 33'(ra);
               si_in = 33'(rai);
               ar_in = 33'(ra);
               ai_in = 33'(rai);
            end
         endcase
      end
   end

   always_comb begin
      m0_in = m0_ff;
      m1_in = m1_ff;
      m2_in = m2_ff;
      m3_in = m3_ff;
      if (ctl.mul) begin
         m0_in = $signed(ctl.coef_a) * ar_ff;
         m1_in = $signed(ctl.coef_b) * ai_ff;
         m2_in = $signed(ctl.coef_a) * ai_ff;
         m3_in = $signed(ctl.coef_b) * ar_ff;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
      si_ff <= si_in;
      ar_ff <= ar_in;
      ai_ff <= ai_in;
      m0_ff <= m0_in;
      m1_ff <= m1_in;
      m2_ff <= m2_in;
      m3_ff <= m3_in;
   end

   // forward: >>15 of (c*ar - s*ai); inverse and ramp: >>16 of (c*ar + s*ai)
   always_comb begin
      fwd  = (ctl.pass == PS_FFT) && !ctl.inv;
      re52 = fwd ? (52'(m0_ff) - 52'(m1_ff)) : (52'(m0_ff) + 52'(m1_ff));
      im52 = fwd ? (52'(m2_ff) + 52'(m3_ff)) : (52'(m2_ff) - 52'(m3_ff));
      re_r = fwd ? ((re52 + 52'sd16384) >>> 15) : ((re52 + 52'sd32768) >>> 16);
      im_r = fwd ? ((im52 + 52'sd16384) >>> 15) : ((im52 + 52'sd32768) >>> 16);
      prod_word = {sat32(re_r), sat32(im_r)};
      hr = (34'(sr_ff) + 34'sd1) >>> 1;
      hi = (34'(si_ff) + 34'sd1) >>> 1;
      if ((ctl.pass == PS_FFT) && ctl.inv) p_word = {sat32(52'(hr)), sat32(52'(hi))};
      else                                 p_word = {sat32(52'(sr_ff)), sat32(52'(si_ff))};
      if (ctl.wq) begin
         wk_wr_data = (ctl.pass == PS_REV) ? {ar_ff[31:0], ai_ff[31:0]} : prod_word;
      end else begin
         wk_wr_data = (ctl.pass == PS_RAMP) ? prod_word : p_word;
      end
      res_wr_data = sat24(sr_ff);
   end

endmodule

// File: rtl/frf_seq.sv
// Pass, stage and address sequencer of the ramp filter row block.
module frf_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output frf_pkg::frf_ctl_type  ctl,
   output frf_pkg::addr_type     ld_rd_addr,
   output frf_pkg::addr_type     wk_a_addr,
   output frf_pkg::addr_type     wk_b_addr,
   output logic                  wk_we,
   output frf_pkg::addr_type     wk_wr_addr,
   output logic                  res_we,
   output frf_pkg::addr_type     res_wr_addr
);
   import frf_pkg::*;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_RD   = 6'b000010,
      PH_CAP  = 6'b000100,
      PH_MUL  = 6'b001000,
      PH_WP   = 6'b010000,
      PH_WQ   = 6'b100000
   } phase_type;

   phase_type phase_ff, phase_in;
   pass_type  pass_ff, pass_in;
   logic      inv_ff, inv_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   addr_type  cnt_ff, cnt_in;
   logic signed [COEF_W-1:0] coef_a_ff, coef_a_in, coef_b_ff, coef_b_in;

   tw_idx_type bf_n, hmask, lo, hi, tw, sidx, cidx;
   addr_type   p_addr, q_addr, h_bit, rev_addr, flip_addr, bin;
   logic       swap, tq, op_last, do_adv;
   logic [15:0] sin_v, cos_mag;
   logic [LOG_LEN+31:0] gain_prod;
   logic [31:0] gain_sum;
   logic signed [COEF_W-1:0] cos_c;

   function automatic addr_type reverse_addr(input addr_type a);
      addr_type r;
      for (int i = 0; i < LOG_LEN; i++) r[i] = a[LOG_LEN-1-i];
      return r;
   endfunction

   // butterfly addressing: n splits into group (hi) and offset (lo)
   always_comb begin
      bf_n   = cnt_ff[LOG_LEN-2:0];
      hmask  = tw_idx_type'({(LOG_LEN-1){1'b1}}) >> stage_ff;
      h_bit  = addr_type'(HALF_LEN) >> stage_ff;
      lo     = bf_n & hmask;
      hi     = bf_n & ~hmask;
      p_addr = {hi, 1'b0} | {1'b0, lo};
      q_addr = p_addr | h_bit;
      tw     = lo << stage_ff;
      tq     = (tw <= tw_idx_type'(QUARTER_LEN));
      // half minus tw wraps to the same value modulo the index width
      sidx   = tq ? tw : (tw_idx_type'(0) - tw);
      cidx   = tq ? (tw_idx_type'(QUARTER_LEN) - tw) : (tw - tw_idx_type'(QUARTER_LEN));
      sin_v   = QSIN_TAB[sidx];
      cos_mag = QSIN_TAB[cidx];
      cos_c   = tq ? $signed({2'b00, cos_mag}) : -$signed({2'b00, cos_mag});
      rev_addr  = reverse_addr(cnt_ff);
      swap      = cnt_ff < rev_addr;
      flip_addr = cnt_ff ^ addr_type'(HALF_LEN);
      bin       = cnt_ff[LOG_LEN-1] ? (addr_type'(0) - cnt_ff) : cnt_ff;
      gain_prod = (LOG_LEN+32)'(bin) * (LOG_LEN+32)'(PI_Q30);
      gain_sum  = gain_prod[LOG_LEN+31:LOG_LEN] + 32'd8192;
      op_last   = (pass_ff == PS_FFT) ? (&bf_n) : (&cnt_ff);
   end

   always_comb begin
      phase_in  = phase_ff;
      pass_in   = pass_ff;
      inv_in    = inv_ff;
      stage_in  = stage_ff;
      cnt_in    = cnt_ff;
      coef_a_in = coef_a_ff;
      coef_b_in = coef_b_ff;
      do_adv    = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_RD;
               pass_in  = PS_COPY;
               inv_in   = 1'b0;
               stage_in = '0;
               cnt_in   = '0;
            end
         end
         PH_RD: begin
            phase_in = PH_CAP;
            if (pass_ff == PS_RAMP) begin
               coef_a_in = $signed(gain_sum[31:14]);
               coef_b_in = '0;
            end else begin
               coef_a_in = cos_c;
               coef_b_in = $signed({2'b00, sin_v});
            end
         end
         PH_CAP: phase_in = PH_MUL;
         PH_MUL: phase_in = PH_WP;
         PH_WP: begin
            if ((pass_ff == PS_FFT) || (pass_ff == PS_REV)) phase_in = PH_WQ;
            else                                            do_adv   = 1'b1;
         end
         PH_WQ: do_adv = 1'b1;
         default: phase_in = PH_IDLE;
      endcase
      if (do_adv) begin
         phase_in = PH_RD;
         if (!op_last) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            cnt_in = '0;
            case (pass_ff)
               PS_COPY: begin
                  pass_in  = PS_FFT;
                  stage_in = '0;
               end
               PS_FFT: begin
                  if (stage_ff == STAGE_W'(LOG_LEN - 1)) pass_in = PS_REV;
                  else stage_in = stage_ff + 1'b1;
               end
               PS_REV: pass_in = inv_ff ? PS_OUT : PS_RAMP;
               PS_RAMP: begin
                  pass_in  = PS_FFT;
                  inv_in   = 1'b1;
                  stage_in = '0;
               end
               PS_OUT:  phase_in = PH_IDLE;
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pass_ff  <= PS_COPY;
         inv_ff   <= 1'b0;
         stage_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pass_ff  <= pass_in;
         inv_ff   <= inv_in;
         stage_ff <= stage_in;
         cnt_ff   <= cnt_in;
      end
      coef_a_ff <= coef_a_in;
      coef_b_ff <= coef_b_in;
   end

   always_comb begin
      busy        = (phase_ff != PH_IDLE);
      ctl.pass    = pass_ff;
      ctl.inv     = inv_ff;
      ctl.cap     = (phase_ff == PH_CAP);
      ctl.mul     = (phase_ff == PH_MUL);
      ctl.wq      = (phase_ff == PH_WQ);
      ctl.coef_a  = coef_a_ff;
      ctl.coef_b  = coef_b_ff;
      ld_rd_addr  = flip_addr;
      wk_a_addr   = (pass_ff == PS_FFT) ? p_addr : ((pass_ff == PS_OUT) ? flip_addr : cnt_ff);
      wk_b_addr   = (pass_ff == PS_FFT) ? q_addr : rev_addr;
      wk_wr_addr  = (phase_ff == PH_WQ) ? wk_b_addr : ((pass_ff == PS_FFT) ? p_addr : cnt_ff);
      wk_we       = ((phase_ff == PH_WP) && (pass_ff != PS_OUT) &&
                     ((pass_ff != PS_REV) || swap)) ||
                    ((phase_ff == PH_WQ) && ((pass_ff == PS_FFT) || swap));
      res_we      = (phase_ff == PH_WP) && (pass_ff == PS_OUT);
      res_wr_addr = cnt_ff;
   end

`ifndef SYNTHESIS
   a_we_phase: assert property (@(posedge clock) disable iff (reset)
      wk_we |-> (phase_ff == PH_WP || phase_ff == PH_WQ))
      else $error("work write outside a write phase");
   a_res_pass: assert property (@(posedge clock) disable iff (reset)
      res_we |-> (pass_ff == PS_OUT))
      else $error("result write outside the output pass");
   a_fft_cnt: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE && pass_ff == PS_FFT) |-> !cnt_ff[LOG_LEN-1])
      else $error("butterfly count beyond half length");
`endif

endmodule

// File: rtl/fft_ramp_filter_row.sv
// Top level of the ramp filter row block: item channel, memories and engine.
//
// Use: samples of a projection row enter on the req_ channel, one per
// transaction, req_last_in marking the final one. Each transaction returns
// one rsp_ transaction: the sample at the same position of the previously
// filtered row (zero, with rsp_row_ready low, until a row has been filtered),
// and rsp_last_out copied from req_last_in.
// A result passes through the pending register into the output register; the
// input takes no new transaction while the previous one is still pending.
// On the transaction carrying req_last_in the filter engine runs and req_ready
// stays low until it is done. The time is set by the single butterfly unit,
// which takes each butterfly through read, capture, multiply and two
// write-backs through the one write port of the work memory.
// Reset (synchronous, active high) clears the position counter, the row flag
// and the handshake state; memory contents are not cleared, the output is
// forced to zero until the first row is done.
// A stalled receiver holds the result in the output register; no further
// transaction is taken until that result is taken.
module fft_ramp_filter_row (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [frf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [frf_pkg::RESULT_W-1:0] rsp_filtered,
   output logic                                rsp_last_out,
   output logic                                rsp_row_ready
);
   import frf_pkg::*;

   addr_type idx_ff, idx_in;
   logic     have_row_ff, have_row_in;
   logic     pend_ff, pend_in, pend_last_ff, pend_last_in, pend_row_ff, pend_row_in;
   logic     rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in, rsp_row_ff, rsp_row_in;
   logic [RESULT_W-1:0] rsp_filt_ff, rsp_filt_in;
   logic     req_fire, start, busy;

   frf_ctl_type ctl;
   addr_type    ld_rd_addr, wk_a_addr, wk_b_addr, wk_wr_addr, res_wr_addr;
   logic        wk_we, res_we;
   logic [SAMPLE_W-1:0]   ld_rd_data;
   logic [2*WORK_W-1:0]   wk_a_data, wk_b_data, wk_wr_data;
   logic [RESULT_W-1:0]   res_wr_data, res_rd_data;

   // transaction handshake and row position
   always_comb begin
      req_ready    = !busy && !pend_ff && (!rsp_valid_ff || rsp_ready);
      req_fire     = req_valid && req_ready;
      start        = req_fire && req_last_in;
      idx_in       = req_fire ? (req_last_in ? '0 : idx_ff + 1'b1) : idx_ff;
      have_row_in  = have_row_ff || start;
      pend_in      = req_fire;
      pend_last_in = req_fire ? req_last_in : pend_last_ff;
      pend_row_in  = req_fire ? have_row_ff : pend_row_ff;
      // result memory data arrives the cycle after acceptance
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_filt_in  = pend_row_ff ? res_rd_data : '0;
         rsp_last_in  = pend_last_ff;
         rsp_row_in   = pend_row_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_filt_in  = rsp_filt_ff;
         rsp_last_in  = rsp_last_ff;
         rsp_row_in   = rsp_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         have_row_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         have_row_ff  <= have_row_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_last_ff <= pend_last_in;
      pend_row_ff  <= pend_row_in;
      rsp_filt_ff  <= rsp_filt_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_row_ff   <= rsp_row_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filt_ff;
   assign rsp_last_out  = rsp_last_ff;
   assign rsp_row_ready = rsp_row_ff;

   // incoming row
   frf_ram #(.WIDTH(SAMPLE_W), .DEPTH(ROW_LENGTH)) u_load_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (idx_ff),
      .wr_data (req_sample),
      .rd_addr (ld_rd_addr),
      .rd_data (ld_rd_data)
   );

   // work memory held twice so both butterfly legs are read in the same cycle
   frf_ram #(.WIDTH(2*WORK_W), .DEPTH(ROW_LENGTH)) u_work_a_ram (
      .clock   (clock),
      .wr_en   (wk_we),
      .wr_addr (wk_wr_addr),
      .wr_data (wk_wr_data),
      .rd_addr (wk_a_addr),
      .rd_data (wk_a_data)
   );

   frf_ram #(.WIDTH(2*WORK_W), .DEPTH(ROW_LENGTH)) u_work_b_ram (
      .clock   (clock),
      .wr_en   (wk_we),
      .wr_addr (wk_wr_addr),
      .wr_data (wk_wr_data),
      .rd_addr (wk_b_addr),
      .rd_data (wk_b_data)
   );

   // filtered row, read back by position
   frf_ram #(.WIDTH(RESULT_W), .DEPTH(ROW_LENGTH)) u_result_ram (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (res_wr_addr),
      .wr_data (res_wr_data),
      .rd_addr (idx_ff),
      .rd_data (res_rd_data)
   );

   frf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .ctl         (ctl),
      .ld_rd_addr  (ld_rd_addr),
      .wk_a_addr   (wk_a_addr),
      .wk_b_addr   (wk_b_addr),
      .wk_we       (wk_we),
      .wk_wr_addr  (wk_wr_addr),
      .res_we      (res_we),
      .res_wr_addr (res_wr_addr)
   );

   frf_bfly u_bfly (
      .clock       (clock),
      .ctl         (ctl),
      .wk_a_data   (wk_a_data),
      .wk_b_data   (wk_b_data),
      .ld_data     (ld_rd_data),
      .wk_wr_data  (wk_wr_data),
      .res_wr_data (res_wr_data)
   );

`ifndef SYNTHESIS
   a_pend_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("filter engine did not start on last sample");
   a_row_sticky: assert property (@(posedge clock) disable iff (reset)
      have_row_ff |=> have_row_ff)
      else $error("row flag dropped");
`endif

endmodule

// File: tb/fft_ramp_filter_row_tb.sv
// Self-checking testbench of the ramp filter row block, with its own fixed-point predictor.
`timescale 1ns / 1ps

module fft_ramp_filter_row_tb;

   import frf_pkg::*;

   localparam int    N         = ROW_LENGTH;
   localparam int    HALF      = N / 2;
   localparam int    QUARTER   = N / 4;
   localparam int    NUM_ITEMS = 1750;
   localparam int    FIRST_ROW = N + 16;  // first row overruns, so the position wraps
   localparam int    STALL_MAX = 400000;  // cycles without any transaction
   localparam int    HOLD_LEN  = 400;     // long receiver hold-off
   localparam longint unsigned PI_Q30_TB = 64'd3373259426;

   // idling phases
   localparam int    IDLE_RX_HEAVY = 0;   // sender light, receiver heavy
   localparam int    IDLE_TX_HEAVY = 1;   // swapped
   localparam int    IDLE_NONE     = 2;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_last_in = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [RESULT_W-1:0] rsp_filtered;
   logic                       rsp_last_out;
   logic                       rsp_row_ready;

   // a directed transaction may carry a typed-in result, held beside the payload
   logic                       known_valid = 1'b0;
   logic signed [RESULT_W-1:0] known_filtered = '0;
   logic                       known_row_ready = 1'b0;

   fft_ramp_filter_row uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample   (req_sample),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered),
      .rsp_last_out (rsp_last_out),
      .rsp_row_ready(rsp_row_ready)
   );

   always #5 clock = ~clock;

   typedef struct {
      logic signed [RESULT_W-1:0] filtered;
      logic                       last_out;
      logic                       row_ready;
   } filt_result_type;

   filt_result_type pending_results[$];

   // test control
   int idle_phase = IDLE_RX_HEAVY;
   int items_sent = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   // ------------------------------------------------------------------
   // Predictor: row store, filtered row and FFT working arrays
   // ------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] row_store [N];
   logic signed [RESULT_W-1:0] filt_row  [N];
   int unsigned                row_pos;
   bit                         row_done;
   longint                     acc_re [N];
   longint                     acc_im [N];
   longint                     tw_s [HALF];
   longint                     tw_c [HALF];
   longint                     ramp [N];

   // add half then floor (arithmetic shift)
   function automatic longint round_half(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647)  return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [RESULT_W-1:0] clip24(longint v);
      if (v > 64'sd8388607)  return 24'sd8388607;
      if (v < -64'sd8388608) return -24'sd8388608;
      return v[RESULT_W-1:0];
   endfunction

   // Q1.15 sine of 2*pi*m/N for the first quarter, Taylor series in Q30
   function automatic longint sine_q15(int unsigned m);
      longint unsigned x, x2, term, total, q;
      x     = (64'd2 * PI_Q30_TB * 64'(m)) / 64'(N);
      x2    = (x * x) >> 30;
      term  = x;
      total = x;
      for (int unsigned n = 1; n <= 12; n++) begin
         term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
         if (n[0]) total = total - term;
         else      total = total + term;
      end
      q = (total + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      return longint'(q);
   endfunction

   task automatic build_coefficients();
      longint unsigned bin;
      for (int k = 0; k < HALF; k++) begin
         tw_s[k] = (k <= QUARTER) ? sine_q15(k) : sine_q15(HALF - k);
         tw_c[k] = (k <= QUARTER) ? sine_q15(QUARTER - k) : -sine_q15(k - QUARTER);
      end
      for (int k = 0; k < N; k++) begin
         bin     = (k < HALF) ? k : N - k;
         ramp[k] = longint'(((bin * PI_Q30_TB) / 64'(N) + 64'd8192) >> 14);
      end
   endtask

   // radix-2 DIF, then bit-reversed reordering
   function automatic void transform(bit inverse);
      int     step, p, q, j;
      longint c, s, dr, di, sr, si, rr, ri, t;
      for (int h = HALF; h >= 1; h = h / 2) begin
         step = HALF / h;
         for (int k = 0; k < h; k++) begin
            c = tw_c[(k * step) % HALF];
            s = tw_s[(k * step) % HALF];
            for (int b = 0; b < N; b += 2 * h) begin
               p  = b + k;
               q  = p + h;
               dr = acc_re[p] - acc_re[q];
               di = acc_im[p] - acc_im[q];
               sr = acc_re[p] + acc_re[q];
               si = acc_im[p] + acc_im[q];
               if (!inverse) begin
                  rr = round_half(c * dr - s * di, 15);
                  ri = round_half(c * di + s * dr, 15);
               end else begin
                  sr = round_half(sr, 1);
                  si = round_half(si, 1);
                  rr = round_half(c * dr + s * di, 16);
                  ri = round_half(c * di - s * dr, 16);
               end
               acc_re[p] = clip32(sr);
               acc_im[p] = clip32(si);
               acc_re[q] = clip32(rr);
               acc_im[q] = clip32(ri);
            end
         end
      end
      for (int i = 0; i < N; i++) begin
         j = 0;
         for (int bit_n = 0; bit_n < LOG_LEN; bit_n++) j = (j << 1) | ((i >> bit_n) & 1);
         if (i < j) begin
            t = acc_re[i]; acc_re[i] = acc_re[j]; acc_re[j] = t;
            t = acc_im[i]; acc_im[i] = acc_im[j]; acc_im[j] = t;
         end
      end
   endfunction

   function automatic void ramp_filter_row();
      for (int j = 0; j < HALF; j++) begin
         acc_re[j]        = row_store[j + HALF];
         acc_re[j + HALF] = row_store[j];
         acc_im[j]        = 0;
         acc_im[j + HALF] = 0;
      end
      transform(1'b0);
      for (int j = 0; j < N; j++) begin
         acc_re[j] = clip32(round_half(acc_re[j] * ramp[j], 16));
         acc_im[j] = clip32(round_half(acc_im[j] * ramp[j], 16));
      end
      transform(1'b1);
      for (int j = 0; j < HALF; j++) begin
         filt_row[j]        = clip24(acc_re[j + HALF]);
         filt_row[j + HALF] = clip24(acc_re[j]);
      end
   endfunction

   // one accepted sample: returns the previous row's value at this position
   function automatic filt_result_type take_sample(logic signed [SAMPLE_W-1:0] smp, logic lst);
      filt_result_type r;
      r.filtered  = filt_row[row_pos];
      r.last_out  = lst;
      r.row_ready = row_done;
      row_store[row_pos] = smp;
      if (lst) begin
         ramp_filter_row();
         row_pos  = 0;
         row_done = 1'b1;
      end else begin
         row_pos = (row_pos + 1) % N;
      end
      return r;
   endfunction

   initial begin
      build_coefficients();
      for (int i = 0; i < N; i++) filt_row[i] = '0;
      row_pos  = 0;
      row_done = 1'b0;
   end

   // ------------------------------------------------------------------
   // Monitor: predicts on each input transaction, checks each result
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      filt_result_type predicted, want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("fft_ramp_filter_row verification failed");
            $finish;
         end
         if (req_valid && req_ready) begin
            predicted = take_sample(req_sample, req_last_in);
            // typed-in values replace the prediction on directed rows
            if (known_valid) begin
               predicted.filtered  = known_filtered;
               predicted.row_ready = known_row_ready;
            end
            pending_results.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_filtered !== want.filtered) begin
                  $error("filtered: expected %0d, got %0d", want.filtered, rsp_filtered);
                  fail_count++;
               end
               if (rsp_last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp_last_out);
                  fail_count++;
               end
               if (rsp_row_ready !== want.row_ready) begin
                  $error("row_ready: expected %0b, got %0b", want.row_ready, rsp_row_ready);
                  fail_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random back-pressure, plus one long hold-off
   // ------------------------------------------------------------------
   initial begin
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && items_sent >= 1150) begin
            // long hold: block fills and stalls its input while the sender keeps offering
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end
         case (idle_phase)
            IDLE_RX_HEAVY: rsp_ready <= ($urandom_range(99) >= 45);
            IDLE_TX_HEAVY: rsp_ready <= ($urandom_range(99) >= 8);
            default:       rsp_ready <= 1'b1;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   typedef struct {
      logic signed [SAMPLE_W-1:0] smp;
      logic                       lst;
   } dir_row_type;

   // directed rows, all before the first row ends: output still zero, row flag low
   dir_row_type directed_rows[] = '{
      '{-16'sd32768, 1'b0}, '{16'sd32767, 1'b0}, '{16'sd0, 1'b0},
      '{-16'sd1, 1'b0},     '{16'sd1, 1'b0},     '{16'sh5555, 1'b0},
      '{16'shAAAA, 1'b0},   '{16'sd32767, 1'b0}, '{-16'sd32768, 1'b0},
      '{16'sd32767, 1'b0},  '{-16'sd32768, 1'b0}, '{16'sd256, 1'b0},
      '{-16'sd256, 1'b0},   '{16'sh0F0F, 1'b0},  '{16'shF0F0, 1'b0},
      '{16'sd12345, 1'b0},  '{-16'sd12345, 1'b0}, '{16'sd2, 1'b0},
      '{-16'sd2, 1'b0},     '{16'sh7FFE, 1'b0}
   };

   // present one transaction and hold it until taken
   task automatic offer(logic signed [SAMPLE_W-1:0] smp, logic lst, bit known);
      int gap;
      case (idle_phase)
         IDLE_RX_HEAVY: gap = ($urandom_range(99) < 8) ? $urandom_range(1, 4) : 0;
         IDLE_TX_HEAVY: gap = ($urandom_range(99) < 45) ? $urandom_range(1, 4) : 0;
         default:       gap = 0;
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= smp;
      req_last_in     <= lst;
      known_valid     <= known;
      known_filtered  <= '0;
      known_row_ready <= 1'b0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (items_sent == 600) idle_phase = IDLE_TX_HEAVY;
      if (items_sent == 1200) idle_phase = IDLE_NONE;
   endtask

   // random sample content: mostly full range, some extremes, some smooth runs
   function automatic logic signed [SAMPLE_W-1:0] pick_sample(int pos);
      case ($urandom_range(9))
         0:       return ($urandom_range(1)) ? 16'sd32767 : -16'sd32768;
         1, 2:    return 16'(pos * 97 - 20000);
         3:       return 16'($urandom_range(63)) - 16'sd32;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int row_len, pos, total;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer(directed_rows[i].smp, directed_rows[i].lst, 1'b1);

      // complete the first row past N so every stored entry is written and the index wraps
      for (pos = directed_rows.size(); pos < FIRST_ROW; pos++)
         offer(pick_sample(pos), pos == FIRST_ROW - 1, 1'b0);

      // shorter rows: the rest of each stored row keeps stale entries of earlier rows
      total = FIRST_ROW;
      while (total < NUM_ITEMS) begin
         row_len = ($urandom_range(7) == 0) ? 1 : $urandom_range(20, 140);
         for (pos = 0; pos < row_len; pos++) begin
            offer(pick_sample(pos), pos == row_len - 1, 1'b0);
            total++;
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("fft_ramp_filter_row verification clean");
      end else begin
         $display("fft_ramp_filter_row verification failed");
      end
      $finish;
   end

endmodule
